>>> rtl/aetr_pkg.sv
// Shared types, command codes and character constants for the escape text renderer.
// No dependencies; used by aetr_ctrl, aetr_dp and the top level.
package aetr_pkg;

    localparam int MAX_PARAMS_DEF = 16;

    localparam logic [9:0] PARAM_LIMIT = 10'd1023;

    localparam logic [7:0] CH_LF     = 8'd10;
    localparam logic [7:0] CH_CR     = 8'd13;
    localparam logic [7:0] CH_ESC    = 8'd27;
    localparam logic [7:0] CH_DEL    = 8'd127;
    localparam logic [7:0] CH_SPACE  = 8'd32;
    localparam logic [7:0] CH_LBR    = 8'h5B;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_UP     = 8'h41;
    localparam logic [7:0] CH_DOWN   = 8'h42;
    localparam logic [7:0] CH_RIGHT  = 8'h43;
    localparam logic [7:0] CH_LEFT   = 8'h44;
    localparam logic [7:0] CH_POS    = 8'h48;
    localparam logic [7:0] CH_ED     = 8'h4A;
    localparam logic [7:0] CH_EL     = 8'h4B;
    localparam logic [7:0] CH_SGR    = 8'h6D;
    localparam logic [7:0] CH_SAVE   = 8'h73;
    localparam logic [7:0] CH_REST   = 8'h75;

    localparam logic [1:0] ACT_WRITE     = 2'd0;
    localparam logic [1:0] ACT_ERASE_ALL = 2'd1;
    localparam logic [1:0] ACT_ERASE_EOL = 2'd2;

    localparam logic CFG_COLS = 1'b0;
    localparam logic CFG_ROWS = 1'b1;

    localparam logic [7:0] COLS_RST = 8'd80;
    localparam logic [7:0] ROWS_RST = 8'd24;
    localparam logic [2:0] FG_RST   = 3'd7;
    localparam logic [2:0] BG_RST   = 3'd0;

    localparam logic [9:0] SGR_RESET    = 10'd0;
    localparam logic [9:0] SGR_BOLD     = 10'd1;
    localparam logic [9:0] SGR_FAINT    = 10'd2;
    localparam logic [9:0] SGR_BOLD_OFF = 10'd21;
    localparam logic [9:0] SGR_NORMAL   = 10'd22;
    localparam logic [9:0] SGR_UNDER    = 10'd4;
    localparam logic [9:0] SGR_BLINK    = 10'd5;
    localparam logic [9:0] SGR_REV      = 10'd7;
    localparam logic [9:0] SGR_UNDER_OFF = 10'd24;
    localparam logic [9:0] SGR_BLINK_OFF = 10'd25;
    localparam logic [9:0] SGR_REV_OFF  = 10'd27;
    localparam logic [9:0] SGR_FG_LO    = 10'd30;
    localparam logic [9:0] SGR_FG_HI    = 10'd37;
    localparam logic [9:0] SGR_BG_LO    = 10'd40;
    localparam logic [9:0] SGR_BG_HI    = 10'd47;
    localparam logic [2:0] UNDER_FG     = 3'd4;

    localparam int ATTR_BOLD  = 0;
    localparam int ATTR_UNDER = 1;
    localparam int ATTR_BLINK = 2;
    localparam int ATTR_REV   = 3;

    localparam logic [3:0] OP_NONE     = 4'd0;
    localparam logic [3:0] OP_LOAD     = 4'd1;
    localparam logic [3:0] OP_CLEAR    = 4'd2;
    localparam logic [3:0] OP_DIGIT_RD = 4'd3;
    localparam logic [3:0] OP_DIGIT_WR = 4'd4;
    localparam logic [3:0] OP_SEMI     = 4'd5;
    localparam logic [3:0] OP_ARG_RD0  = 4'd6;
    localparam logic [3:0] OP_ARG_RD1  = 4'd7;
    localparam logic [3:0] OP_EXEC     = 4'd8;
    localparam logic [3:0] OP_SGR_RST  = 4'd9;
    localparam logic [3:0] OP_SGR_RD   = 4'd10;
    localparam logic [3:0] OP_SGR_STEP = 4'd11;
    localparam logic [3:0] OP_EMIT     = 4'd12;

    typedef struct packed {
        logic [3:0] op;
    } cmd_t;

    typedef struct packed {
        logic is_cr;
        logic is_esc;
        logic is_lbr;
        logic is_digit;
        logic is_semi;
        logic is_ctrl;
        logic fin_emit;
        logic fin_sgr;
        logic cnt_ok;
        logic sgr_empty;
        logic sgr_last;
        logic out_free;
    } sts_t;

    typedef struct packed {
        logic [2:0] fg;
        logic [2:0] bg;
        logic [3:0] attr;
    } style_t;

endpackage

>>> rtl/aetr_ctrl.sv
// Sequencer for the escape text renderer: parse phase and per-byte step control.
// Depends on aetr_pkg; drives aetr_dp through cmd_t and reads sts_t.
module aetr_ctrl
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  aetr_pkg::sts_t  sts,
    output aetr_pkg::cmd_t  cmd
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_DECODE = 3'd1;
    localparam logic [2:0] S_ACC    = 3'd2;
    localparam logic [2:0] S_ARG    = 3'd3;
    localparam logic [2:0] S_EXEC   = 3'd4;
    localparam logic [2:0] S_SGR    = 3'd5;

    localparam logic [1:0] PH_GROUND = 2'd0;
    localparam logic [1:0] PH_ESC    = 2'd1;
    localparam logic [1:0] PH_CSI    = 2'd2;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic [1:0] phase_reg;
    logic [1:0] phase_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            phase_reg <= PH_GROUND;
        end
        else
        begin
            state_reg <= state_next;
            phase_reg <= phase_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        phase_next = phase_reg;
        cmd.op     = aetr_pkg::OP_NONE;
        in_ready   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.op     = aetr_pkg::OP_LOAD;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                if (sts.is_cr)
                begin
                    state_next = S_IDLE;
                end
                else if (phase_reg == PH_ESC)
                begin
                    state_next = S_IDLE;
                    if (sts.is_lbr)
                    begin
                        phase_next = PH_CSI;
                        cmd.op     = aetr_pkg::OP_CLEAR;
                    end
                    else if (!sts.is_esc)
                    begin
                        phase_next = PH_GROUND;
                    end
                end
                else if (phase_reg == PH_CSI)
                begin
                    if (sts.is_digit)
                    begin
                        cmd.op     = aetr_pkg::OP_DIGIT_RD;
                        state_next = sts.cnt_ok ? S_ACC : S_IDLE;
                    end
                    else if (sts.is_semi)
                    begin
                        cmd.op     = aetr_pkg::OP_SEMI;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        phase_next = PH_GROUND;
                        if (sts.fin_sgr && sts.sgr_empty)
                        begin
                            cmd.op     = aetr_pkg::OP_SGR_RST;
                            state_next = S_IDLE;
                        end
                        else if (sts.fin_sgr)
                        begin
                            cmd.op     = aetr_pkg::OP_SGR_RD;
                            state_next = S_SGR;
                        end
                        else
                        begin
                            cmd.op     = aetr_pkg::OP_ARG_RD0;
                            state_next = S_ARG;
                        end
                    end
                end
                else
                begin
                    phase_next = PH_GROUND;
                    if (sts.is_esc)
                    begin
                        phase_next = PH_ESC;
                        state_next = S_IDLE;
                    end
                    else if (sts.is_ctrl)
                    begin
                        state_next = S_IDLE;
                    end
                    else if (sts.out_free)
                    begin
                        cmd.op     = aetr_pkg::OP_EMIT;
                        state_next = S_IDLE;
                    end
                end
            end
            S_ACC:
            begin
                cmd.op     = aetr_pkg::OP_DIGIT_WR;
                state_next = S_IDLE;
            end
            S_ARG:
            begin
                cmd.op     = aetr_pkg::OP_ARG_RD1;
                state_next = S_EXEC;
            end
            S_EXEC:
            begin
                if (!sts.fin_emit || sts.out_free)
                begin
                    cmd.op     = aetr_pkg::OP_EXEC;
                    state_next = S_IDLE;
                end
            end
            S_SGR:
            begin
                cmd.op = aetr_pkg::OP_SGR_STEP;
                if (sts.sgr_last)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == aetr_pkg::OP_EMIT) || (cmd.op == aetr_pkg::OP_EXEC && sts.fin_emit)
        |-> sts.out_free)
        else $error("result issued while output register is held");

    a_acc_from_csi: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_ACC) |-> ($past(state_reg) == S_DECODE && $past(phase_reg) == PH_CSI))
        else $error("digit accumulate outside a control sequence");

    a_csi_from_esc: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_CSI && $past(phase_reg) != PH_CSI) |-> ($past(phase_reg) == PH_ESC))
        else $error("control sequence entered without escape");

endmodule

>>> rtl/aetr_dp.sv
// Datapath for the escape text renderer: parameter buffer, cursor, style and result register.
// Depends on aetr_pkg; controlled by aetr_ctrl through cmd_t, reports sts_t.
module aetr_dp
#(
    parameter int MAX_PARAMS = aetr_pkg::MAX_PARAMS_DEF
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  aetr_pkg::cmd_t  cmd,
    output aetr_pkg::sts_t  sts,
    input  logic [7:0]      text_byte,
    input  logic            cfg_we,
    input  logic            cfg_index,
    input  logic [7:0]      cfg_data,
    output logic            out_valid,
    input  logic            out_ready,
    output logic [1:0]      action,
    output logic [7:0]      row,
    output logic [7:0]      column,
    output logic [7:0]      glyph,
    output logic [2:0]      foreground,
    output logic [2:0]      background,
    output logic            bold_on,
    output logic            underline_on,
    output logic            blink_on,
    output logic            reverse_on
);

    localparam int IDX_W = $clog2(MAX_PARAMS);
    localparam int CNT_W = $clog2(MAX_PARAMS + 2);

    logic [7:0]            byte_reg;
    logic [7:0]            cols_reg;
    logic [7:0]            rows_reg;
    logic [9:0]            mem [MAX_PARAMS];
    logic [MAX_PARAMS-1:0] vld_reg;
    logic [CNT_W-1:0]      cnt_reg;
    logic [CNT_W-1:0]      cnt_next;
    logic [IDX_W-1:0]      idx_reg;
    logic [IDX_W-1:0]      idx_next;
    logic [9:0]            rdata_reg;
    logic [9:0]            arg0_reg;
    logic [7:0]            row_reg, row_next;
    logic [7:0]            col_reg, col_next;
    logic [7:0]            srow_reg, srow_next;
    logic [7:0]            scol_reg, scol_next;
    aetr_pkg::style_t      style_reg, style_next;
    logic                  out_valid_reg, out_valid_next;
    logic [1:0]            act_reg, act_next;
    logic [7:0]            orow_reg, orow_next;
    logic [7:0]            ocol_reg, ocol_next;
    logic [7:0]            glyph_reg, glyph_next;
    aetr_pkg::style_t      ostyle_reg;

    logic [7:0]            last_row, last_col;
    logic [7:0]            new_cols, new_rows, new_last_row, new_last_col;
    logic [CNT_W-1:0]      eff_cnt, sgr_k;
    logic                  rd_en, mem_we, emit_en;
    logic [IDX_W-1:0]      rd_addr, wr_addr;
    logic [13:0]           acc;
    logic [9:0]            wdata;
    logic [9:0]            step_n, pos_r, pos_c;
    logic                  out_free;

    function automatic aetr_pkg::style_t sgr_apply(aetr_pkg::style_t s, logic [9:0] n);
        aetr_pkg::style_t r;
        logic [9:0]       d;
        r = s;
        d = 10'd0;
        case (n) inside
            aetr_pkg::SGR_RESET:
            begin
                r.attr = 4'd0;
                r.fg   = aetr_pkg::FG_RST;
                r.bg   = aetr_pkg::BG_RST;
            end
            aetr_pkg::SGR_BOLD:      r.attr[aetr_pkg::ATTR_BOLD] = 1'b1;
            aetr_pkg::SGR_FAINT, aetr_pkg::SGR_BOLD_OFF, aetr_pkg::SGR_NORMAL:
                r.attr[aetr_pkg::ATTR_BOLD] = 1'b0;
            aetr_pkg::SGR_UNDER:
            begin
                r.attr[aetr_pkg::ATTR_UNDER] = 1'b1;
                r.fg = aetr_pkg::UNDER_FG;
            end
            aetr_pkg::SGR_BLINK:     r.attr[aetr_pkg::ATTR_BLINK] = 1'b1;
            aetr_pkg::SGR_REV:
            begin
                r.attr[aetr_pkg::ATTR_REV] = 1'b1;
                r.fg = s.bg;
                r.bg = s.fg;
            end
            aetr_pkg::SGR_UNDER_OFF: r.attr[aetr_pkg::ATTR_UNDER] = 1'b0;
            aetr_pkg::SGR_BLINK_OFF: r.attr[aetr_pkg::ATTR_BLINK] = 1'b0;
            aetr_pkg::SGR_REV_OFF:
            begin
                r.attr[aetr_pkg::ATTR_REV] = 1'b0;
                r.fg = s.bg;
                r.bg = s.fg;
            end
            [aetr_pkg::SGR_FG_LO:aetr_pkg::SGR_FG_HI]:
            begin
                d    = n - aetr_pkg::SGR_FG_LO;
                r.fg = d[2:0];
            end
            [aetr_pkg::SGR_BG_LO:aetr_pkg::SGR_BG_HI]:
            begin
                d    = n - aetr_pkg::SGR_BG_LO;
                r.bg = d[2:0];
            end
            default: ;
        endcase
        return r;
    endfunction

    // zero-sized screen acts as one cell
    assign last_row = (rows_reg == 8'd0) ? 8'd0 : rows_reg - 8'd1;
    assign last_col = (cols_reg == 8'd0) ? 8'd0 : cols_reg - 8'd1;
    assign new_cols = (cfg_index == aetr_pkg::CFG_COLS) ? cfg_data : cols_reg;
    assign new_rows = (cfg_index == aetr_pkg::CFG_ROWS) ? cfg_data : rows_reg;
    assign new_last_col = (new_cols == 8'd0) ? 8'd0 : new_cols - 8'd1;
    assign new_last_row = (new_rows == 8'd0) ? 8'd0 : new_rows - 8'd1;

    assign eff_cnt = (cnt_reg == '0) ? CNT_W'(1) : cnt_reg;
    assign sgr_k   = (cnt_reg > CNT_W'(MAX_PARAMS)) ? CNT_W'(MAX_PARAMS) : cnt_reg;
    assign out_free = !out_valid_reg || out_ready;
    assign emit_en = (cmd.op == aetr_pkg::OP_EMIT) ||
                     (cmd.op == aetr_pkg::OP_EXEC && sts.fin_emit);

    always_comb
    begin
        sts.is_cr     = (byte_reg == aetr_pkg::CH_CR);
        sts.is_esc    = (byte_reg == aetr_pkg::CH_ESC);
        sts.is_lbr    = (byte_reg == aetr_pkg::CH_LBR);
        sts.is_digit  = (byte_reg >= aetr_pkg::CH_ZERO) && (byte_reg <= aetr_pkg::CH_NINE);
        sts.is_semi   = (byte_reg == aetr_pkg::CH_SEMI);
        sts.is_ctrl   = ((byte_reg < aetr_pkg::CH_SPACE) && (byte_reg != aetr_pkg::CH_LF)) ||
                        (byte_reg == aetr_pkg::CH_DEL);
        sts.fin_emit  = (byte_reg == aetr_pkg::CH_ED) || (byte_reg == aetr_pkg::CH_EL);
        sts.fin_sgr   = (byte_reg == aetr_pkg::CH_SGR);
        sts.cnt_ok    = (eff_cnt <= CNT_W'(MAX_PARAMS));
        sts.sgr_empty = (cnt_reg == '0);
        sts.sgr_last  = ((CNT_W'(idx_reg) + CNT_W'(1)) == sgr_k);
        sts.out_free  = out_free;
    end

    // parameter buffer ports
    always_comb
    begin
        rd_en   = 1'b1;
        rd_addr = '0;
        unique case (cmd.op)
            aetr_pkg::OP_DIGIT_RD: rd_addr = IDX_W'(eff_cnt - CNT_W'(1));
            aetr_pkg::OP_ARG_RD0:  rd_addr = '0;
            aetr_pkg::OP_SGR_RD:   rd_addr = '0;
            aetr_pkg::OP_ARG_RD1:  rd_addr = IDX_W'(1);
            aetr_pkg::OP_SGR_STEP: rd_addr = idx_reg + IDX_W'(1);
            default:               rd_en   = 1'b0;
        endcase
    end

    assign mem_we  = (cmd.op == aetr_pkg::OP_DIGIT_WR);
    assign wr_addr = IDX_W'(cnt_reg - CNT_W'(1));
    assign acc     = ({4'd0, rdata_reg} << 3) + ({4'd0, rdata_reg} << 1) +
                     {10'd0, byte_reg[3:0]};
    assign wdata   = (acc > {4'd0, aetr_pkg::PARAM_LIMIT}) ? aetr_pkg::PARAM_LIMIT : acc[9:0];

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[wr_addr] <= wdata;
        end
        if (rd_en)
        begin
            rdata_reg <= vld_reg[rd_addr] ? mem[rd_addr] : 10'd0;
        end
    end

    always_comb
    begin
        cnt_next = cnt_reg;
        idx_next = idx_reg;
        unique case (cmd.op)
            aetr_pkg::OP_CLEAR:    cnt_next = '0;
            aetr_pkg::OP_DIGIT_RD: cnt_next = eff_cnt;
            aetr_pkg::OP_SEMI:     cnt_next = sts.cnt_ok ? eff_cnt + CNT_W'(1) : eff_cnt;
            aetr_pkg::OP_SGR_RD:   idx_next = '0;
            aetr_pkg::OP_SGR_STEP: idx_next = idx_reg + IDX_W'(1);
            default: ;
        endcase
    end

    assign step_n = (arg0_reg == 10'd0) ? 10'd1 : arg0_reg;
    assign pos_r  = (arg0_reg == 10'd0) ? 10'd0 : arg0_reg - 10'd1;
    assign pos_c  = (rdata_reg == 10'd0) ? 10'd0 : rdata_reg - 10'd1;

    always_comb
    begin
        row_next   = row_reg;
        col_next   = col_reg;
        srow_next  = srow_reg;
        scol_next  = scol_reg;
        style_next = style_reg;
        act_next   = aetr_pkg::ACT_WRITE;
        orow_next  = row_reg;
        ocol_next  = col_reg;
        glyph_next = 8'd0;
        unique case (cmd.op)
            aetr_pkg::OP_EXEC:
            begin
                unique case (byte_reg)
                    aetr_pkg::CH_UP:
                        if (step_n <= {2'd0, row_reg})
                            row_next = row_reg - step_n[7:0];
                    aetr_pkg::CH_DOWN:
                        if (step_n <= {2'd0, last_row - row_reg})
                            row_next = row_reg + step_n[7:0];
                    aetr_pkg::CH_RIGHT:
                        if (step_n <= {2'd0, last_col - col_reg})
                            col_next = col_reg + step_n[7:0];
                    aetr_pkg::CH_LEFT:
                        if (step_n <= {2'd0, col_reg})
                            col_next = col_reg - step_n[7:0];
                    aetr_pkg::CH_POS:
                        if (pos_r <= {2'd0, last_row} && pos_c <= {2'd0, last_col})
                        begin
                            row_next = pos_r[7:0];
                            col_next = pos_c[7:0];
                        end
                    aetr_pkg::CH_ED:
                    begin
                        act_next  = aetr_pkg::ACT_ERASE_ALL;
                        orow_next = 8'd0;
                        ocol_next = 8'd0;
                        row_next  = 8'd0;
                        col_next  = 8'd0;
                    end
                    aetr_pkg::CH_EL:
                        act_next = aetr_pkg::ACT_ERASE_EOL;
                    aetr_pkg::CH_SAVE:
                    begin
                        srow_next = row_reg;
                        scol_next = col_reg;
                    end
                    aetr_pkg::CH_REST:
                    begin
                        row_next = srow_reg;
                        col_next = scol_reg;
                    end
                    default: ;
                endcase
            end
            aetr_pkg::OP_EMIT:
            begin
                if (byte_reg == aetr_pkg::CH_LF)
                begin
                    act_next = aetr_pkg::ACT_ERASE_EOL;
                    col_next = 8'd0;
                    if (row_reg < last_row)
                        row_next = row_reg + 8'd1;
                end
                else
                begin
                    glyph_next = byte_reg;
                    if (col_reg < last_col)
                    begin
                        col_next = col_reg + 8'd1;
                    end
                    else if (row_reg < last_row)
                    begin
                        col_next = 8'd0;
                        row_next = row_reg + 8'd1;
                    end
                end
            end
            aetr_pkg::OP_SGR_RST:  style_next = sgr_apply(style_reg, aetr_pkg::SGR_RESET);
            aetr_pkg::OP_SGR_STEP: style_next = sgr_apply(style_reg, rdata_reg);
            default: ;
        endcase
        // shrinking the screen pulls both cursors inside
        if (cfg_we)
        begin
            if (row_reg > new_last_row)  row_next  = new_last_row;
            if (col_reg > new_last_col)  col_next  = new_last_col;
            if (srow_reg > new_last_row) srow_next = new_last_row;
            if (scol_reg > new_last_col) scol_next = new_last_col;
        end
    end

    assign out_valid_next = emit_en ? 1'b1 : (out_ready ? 1'b0 : out_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cols_reg      <= aetr_pkg::COLS_RST;
            rows_reg      <= aetr_pkg::ROWS_RST;
            vld_reg       <= '0;
            cnt_reg       <= '0;
            idx_reg       <= '0;
            row_reg       <= 8'd0;
            col_reg       <= 8'd0;
            srow_reg      <= 8'd0;
            scol_reg      <= 8'd0;
            style_reg     <= '{fg: aetr_pkg::FG_RST, bg: aetr_pkg::BG_RST, attr: 4'd0};
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                cols_reg <= new_cols;
                rows_reg <= new_rows;
            end
            if (cmd.op == aetr_pkg::OP_CLEAR)
            begin
                vld_reg <= '0;
            end
            else if (mem_we)
            begin
                vld_reg[wr_addr] <= 1'b1;
            end
            cnt_reg       <= cnt_next;
            idx_reg       <= idx_next;
            row_reg       <= row_next;
            col_reg       <= col_next;
            srow_reg      <= srow_next;
            scol_reg      <= scol_next;
            style_reg     <= style_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.op == aetr_pkg::OP_LOAD)
        begin
            byte_reg <= text_byte;
        end
        if (cmd.op == aetr_pkg::OP_ARG_RD1)
        begin
            arg0_reg <= rdata_reg;
        end
        if (emit_en)
        begin
            act_reg    <= act_next;
            orow_reg   <= orow_next;
            ocol_reg   <= ocol_next;
            glyph_reg  <= glyph_next;
            ostyle_reg <= style_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign action       = act_reg;
    assign row          = orow_reg;
    assign column       = ocol_reg;
    assign glyph        = glyph_reg;
    assign foreground   = ostyle_reg.fg;
    assign background   = ostyle_reg.bg;
    assign bold_on      = ostyle_reg.attr[aetr_pkg::ATTR_BOLD];
    assign underline_on = ostyle_reg.attr[aetr_pkg::ATTR_UNDER];
    assign blink_on     = ostyle_reg.attr[aetr_pkg::ATTR_BLINK];
    assign reverse_on   = ostyle_reg.attr[aetr_pkg::ATTR_REV];

    a_row_in_screen: assert property (@(posedge clk) disable iff (!rst_n)
        row_reg <= last_row)
        else $error("cursor row off screen");

    a_col_in_screen: assert property (@(posedge clk) disable iff (!rst_n)
        col_reg <= last_col)
        else $error("cursor column off screen");

    a_saved_in_screen: assert property (@(posedge clk) disable iff (!rst_n)
        (srow_reg <= last_row) && (scol_reg <= last_col))
        else $error("saved cursor off screen");

endmodule

>>> rtl/ansi_escape_text_renderer_unit.sv
// Top level of the escape text renderer: controller plus datapath.
// Depends on aetr_pkg, aetr_ctrl and aetr_dp.
//
//  channel  | handshake             | payload
//  ---------+-----------------------+---------------------------------------------
//  input    | in_valid / in_ready   | text_byte
//  output   | out_valid / out_ready | action row column glyph foreground
//           |                       | background bold_on underline_on blink_on
//           |                       | reverse_on
//  config   | cfg_we                | cfg_index cfg_data
//
// A byte is accepted, then decoded; a digit is then accumulated; a cursor, erase,
// save or restore final reads a second parameter, then executes; an SGR final
// steps through the buffered parameters (one parameter buffer read per cycle).
// Reset clears all control state at once; no sweep of the parameter buffer.
// A byte that writes a result waits while the output register holds an untaken
// transfer; input is accepted again as soon as the sequencer is back in idle.
module ansi_escape_text_renderer_unit
#(
    parameter int MAX_PARAMS = aetr_pkg::MAX_PARAMS_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] text_byte,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [1:0] action,
    output logic [7:0] row,
    output logic [7:0] column,
    output logic [7:0] glyph,
    output logic [2:0] foreground,
    output logic [2:0] background,
    output logic       bold_on,
    output logic       underline_on,
    output logic       blink_on,
    output logic       reverse_on,
    input  logic       cfg_we,
    input  logic       cfg_index,
    input  logic [7:0] cfg_data
);

    aetr_pkg::cmd_t cmd;
    aetr_pkg::sts_t sts;

    aetr_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    aetr_dp
    #(
        .MAX_PARAMS (MAX_PARAMS)
    )
    u_dp
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .sts          (sts),
        .text_byte    (text_byte),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .action       (action),
        .row          (row),
        .column       (column),
        .glyph        (glyph),
        .foreground   (foreground),
        .background   (background),
        .bold_on      (bold_on),
        .underline_on (underline_on),
        .blink_on     (blink_on),
        .reverse_on   (reverse_on)
    );

endmodule

>>> tb/aetr_draw_checker.sv
`timescale 1ns / 100ps
// Draw-stream checker for the escape text renderer: mirrors cursor, style and parser state,
// predicts each draw command from accepted bytes and compares it with the output channel.
// Depends on aetr_pkg.
module aetr_draw_checker
#(
    parameter int MAX_PARAMS = aetr_pkg::MAX_PARAMS_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic       in_ready,
    input  logic [7:0] text_byte,
    input  logic       out_valid,
    input  logic       out_ready,
    input  logic [1:0] action,
    input  logic [7:0] row,
    input  logic [7:0] column,
    input  logic [7:0] glyph,
    input  logic [2:0] foreground,
    input  logic [2:0] background,
    input  logic       bold_on,
    input  logic       underline_on,
    input  logic       blink_on,
    input  logic       reverse_on,
    input  logic       cfg_we,
    input  logic       cfg_index,
    input  logic [7:0] cfg_data,
    output int         fail_count,
    output int         pending
);

    typedef enum logic [1:0] {SEQ_TEXT, SEQ_ESC, SEQ_CSI} seq_phase_t;

    typedef struct packed {
        logic [1:0]       action;
        logic [7:0]       row;
        logic [7:0]       column;
        logic [7:0]       glyph;
        aetr_pkg::style_t style;
    } draw_t;

    logic [7:0]       scr_cols;
    logic [7:0]       scr_rows;
    seq_phase_t       seq_phase;
    logic [9:0]       param_buf [MAX_PARAMS];
    int unsigned      param_cnt;
    int unsigned      cur_r;
    int unsigned      cur_c;
    int unsigned      sav_r;
    int unsigned      sav_c;
    aetr_pkg::style_t sty;
    draw_t            draw_queue [$];

    function automatic int unsigned n_cols();
        return (scr_cols == 8'd0) ? 1 : scr_cols;
    endfunction

    function automatic int unsigned n_rows();
        return (scr_rows == 8'd0) ? 1 : scr_rows;
    endfunction

    function automatic int unsigned param_at(input int unsigned i);
        if (i < param_cnt && i < MAX_PARAMS)
            return param_buf[i];
        return 0;
    endfunction

    function automatic draw_t make_draw(input logic [1:0] act, input int unsigned r,
                                        input int unsigned c, input logic [7:0] g);
        draw_t d;
        d.action = act;
        d.row    = 8'(r);
        d.column = 8'(c);
        d.glyph  = g;
        d.style  = sty;
        return d;
    endfunction

    function automatic void reset_model();
        scr_cols  = aetr_pkg::COLS_RST;
        scr_rows  = aetr_pkg::ROWS_RST;
        seq_phase = SEQ_TEXT;
        foreach (param_buf[i])
            param_buf[i] = '0;
        param_cnt = 0;
        cur_r     = 0;
        cur_c     = 0;
        sav_r     = 0;
        sav_c     = 0;
        sty.fg    = aetr_pkg::FG_RST;
        sty.bg    = aetr_pkg::BG_RST;
        sty.attr  = '0;
    endfunction

    function automatic void apply_config(input logic idx, input logic [7:0] val);
        if (idx == aetr_pkg::CFG_COLS)
            scr_cols = val;
        else
            scr_rows = val;
        if (cur_r > n_rows() - 1) cur_r = n_rows() - 1;
        if (cur_c > n_cols() - 1) cur_c = n_cols() - 1;
        if (sav_r > n_rows() - 1) sav_r = n_rows() - 1;
        if (sav_c > n_cols() - 1) sav_c = n_cols() - 1;
    endfunction

    function automatic void apply_sgr(input logic [9:0] code);
        case (code)
            aetr_pkg::SGR_RESET:
            begin
                sty.attr = '0;
                sty.fg   = aetr_pkg::FG_RST;
                sty.bg   = aetr_pkg::BG_RST;
            end
            aetr_pkg::SGR_BOLD:
                sty.attr[aetr_pkg::ATTR_BOLD] = 1'b1;
            aetr_pkg::SGR_FAINT, aetr_pkg::SGR_BOLD_OFF, aetr_pkg::SGR_NORMAL:
                sty.attr[aetr_pkg::ATTR_BOLD] = 1'b0;
            aetr_pkg::SGR_UNDER:
            begin
                sty.attr[aetr_pkg::ATTR_UNDER] = 1'b1;
                sty.fg = aetr_pkg::UNDER_FG;
            end
            aetr_pkg::SGR_BLINK:
                sty.attr[aetr_pkg::ATTR_BLINK] = 1'b1;
            aetr_pkg::SGR_REV:
            begin
                sty.attr[aetr_pkg::ATTR_REV] = 1'b1;
                {sty.fg, sty.bg} = {sty.bg, sty.fg};
            end
            aetr_pkg::SGR_UNDER_OFF:
                sty.attr[aetr_pkg::ATTR_UNDER] = 1'b0;
            aetr_pkg::SGR_BLINK_OFF:
                sty.attr[aetr_pkg::ATTR_BLINK] = 1'b0;
            aetr_pkg::SGR_REV_OFF:
            begin
                sty.attr[aetr_pkg::ATTR_REV] = 1'b0;
                {sty.fg, sty.bg} = {sty.bg, sty.fg};
            end
            default:
            begin
                if (code >= aetr_pkg::SGR_FG_LO && code <= aetr_pkg::SGR_FG_HI)
                    sty.fg = 3'(code - aetr_pkg::SGR_FG_LO);
                else if (code >= aetr_pkg::SGR_BG_LO && code <= aetr_pkg::SGR_BG_HI)
                    sty.bg = 3'(code - aetr_pkg::SGR_BG_LO);
            end
        endcase
    endfunction

    // Runs one sequence terminator; returns 1 when it produces a draw command.
    function automatic bit run_command(input logic [7:0] b, output draw_t d);
        int unsigned n;
        int unsigned r;
        int unsigned c;
        int unsigned k;
        n = param_at(0);
        if (n == 0) n = 1;
        d = '0;
        case (b)
            aetr_pkg::CH_UP:    if (n <= cur_r) cur_r = cur_r - n;
            aetr_pkg::CH_DOWN:  if (cur_r + n < n_rows()) cur_r = cur_r + n;
            aetr_pkg::CH_RIGHT: if (cur_c + n < n_cols()) cur_c = cur_c + n;
            aetr_pkg::CH_LEFT:  if (n <= cur_c) cur_c = cur_c - n;
            aetr_pkg::CH_POS:
            begin
                r = param_at(0);
                c = param_at(1);
                if (r != 0) r--;
                if (c != 0) c--;
                if (r < n_rows() && c < n_cols())
                begin
                    cur_r = r;
                    cur_c = c;
                end
            end
            aetr_pkg::CH_ED:
            begin
                cur_r = 0;
                cur_c = 0;
                d = make_draw(aetr_pkg::ACT_ERASE_ALL, 0, 0, 8'd0);
                return 1'b1;
            end
            aetr_pkg::CH_EL:
            begin
                d = make_draw(aetr_pkg::ACT_ERASE_EOL, cur_r, cur_c, 8'd0);
                return 1'b1;
            end
            aetr_pkg::CH_SAVE:
            begin
                sav_r = cur_r;
                sav_c = cur_c;
            end
            aetr_pkg::CH_REST:
            begin
                cur_r = sav_r;
                cur_c = sav_c;
            end
            aetr_pkg::CH_SGR:
            begin
                k = (param_cnt < MAX_PARAMS) ? param_cnt : MAX_PARAMS;
                if (k == 0)
                    apply_sgr(aetr_pkg::SGR_RESET);
                for (int i = 0; i < k; i++)
                    apply_sgr(param_buf[i]);
            end
            default: ;
        endcase
        return 1'b0;
    endfunction

    function automatic bit render_byte(input logic [7:0] b, output draw_t d);
        int unsigned v;
        d = '0;
        if (b == aetr_pkg::CH_CR)
            return 1'b0;
        if (seq_phase == SEQ_ESC)
        begin
            if (b == aetr_pkg::CH_LBR)
            begin
                seq_phase = SEQ_CSI;
                foreach (param_buf[i])
                    param_buf[i] = '0;
                param_cnt = 0;
            end
            else if (b != aetr_pkg::CH_ESC)
                seq_phase = SEQ_TEXT;
            return 1'b0;
        end
        if (seq_phase == SEQ_CSI)
        begin
            if (b >= aetr_pkg::CH_ZERO && b <= aetr_pkg::CH_NINE)
            begin
                if (param_cnt == 0) param_cnt = 1;
                if (param_cnt <= MAX_PARAMS)
                begin
                    v = param_buf[param_cnt - 1] * 10 + (b - aetr_pkg::CH_ZERO);
                    if (v > aetr_pkg::PARAM_LIMIT) v = aetr_pkg::PARAM_LIMIT;
                    param_buf[param_cnt - 1] = 10'(v);
                end
                return 1'b0;
            end
            if (b == aetr_pkg::CH_SEMI)
            begin
                if (param_cnt == 0) param_cnt = 1;
                if (param_cnt <= MAX_PARAMS) param_cnt++;
                return 1'b0;
            end
            seq_phase = SEQ_TEXT;
            return run_command(b, d);
        end
        if (b == aetr_pkg::CH_ESC)
        begin
            seq_phase = SEQ_ESC;
            return 1'b0;
        end
        if (b == aetr_pkg::CH_LF)
        begin
            d = make_draw(aetr_pkg::ACT_ERASE_EOL, cur_r, cur_c, 8'd0);
            cur_c = 0;
            if (cur_r + 1 < n_rows()) cur_r++;
            return 1'b1;
        end
        if (b < aetr_pkg::CH_SPACE || b == aetr_pkg::CH_DEL)
            return 1'b0;
        d = make_draw(aetr_pkg::ACT_WRITE, cur_r, cur_c, b);
        if (cur_c + 1 < n_cols())
            cur_c++;
        else if (cur_r + 1 < n_rows())
        begin
            cur_c = 0;
            cur_r++;
        end
        return 1'b1;
    endfunction

    task automatic check_field(input string fname, input int unsigned want,
                               input int unsigned got);
        if (want != got)
        begin
            fail_count++;
            $display("%0t: %s mismatch: expected %0d, actual %0d",
                     $time, fname, want, got);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        draw_t want;
        draw_t next_draw;
        if (!rst_n)
        begin
            reset_model();
            draw_queue.delete();
            pending    = 0;
            fail_count = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (draw_queue.size() == 0)
                begin
                    fail_count++;
                    $display({"%0t: unexpected transfer: expected none, ",
                              "actual action %0d row %0d col %0d glyph %0d"},
                             $time, action, row, column, glyph);
                end
                else
                begin
                    want = draw_queue.pop_front();
                    check_field("action", want.action, action);
                    check_field("row", want.row, row);
                    check_field("column", want.column, column);
                    check_field("glyph", want.glyph, glyph);
                    check_field("foreground", want.style.fg, foreground);
                    check_field("background", want.style.bg, background);
                    check_field("bold_on", want.style.attr[aetr_pkg::ATTR_BOLD], bold_on);
                    check_field("underline_on", want.style.attr[aetr_pkg::ATTR_UNDER],
                                underline_on);
                    check_field("blink_on", want.style.attr[aetr_pkg::ATTR_BLINK], blink_on);
                    check_field("reverse_on", want.style.attr[aetr_pkg::ATTR_REV],
                                reverse_on);
                end
            end
            if (cfg_we)
                apply_config(cfg_index, cfg_data);
            if (in_valid && in_ready)
            begin
                if (render_byte(text_byte, next_draw))
                    draw_queue.push_back(next_draw);
            end
            pending = draw_queue.size();
        end
    end

endmodule

>>> tb/ansi_escape_text_renderer_unit_tb.sv
`timescale 1ns / 100ps
// Testbench top for ansi_escape_text_renderer_unit: clock, reset, byte stream, receiver stalls,
// screen-size changes and verdict. Depends on aetr_pkg, the DUT and aetr_draw_checker.
module ansi_escape_text_renderer_unit_tb;

    localparam int SETTLE_CYCLES = 40;
    localparam int LONG_HOLD     = 400;
    localparam int QUIET_LIMIT   = 4000;
    localparam int PHASE_BYTES   = 125;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_ready;
    logic [7:0] text_byte = 8'd0;
    logic       out_valid;
    logic       out_ready = 1'b0;
    logic [1:0] action;
    logic [7:0] row;
    logic [7:0] column;
    logic [7:0] glyph;
    logic [2:0] foreground;
    logic [2:0] background;
    logic       bold_on;
    logic       underline_on;
    logic       blink_on;
    logic       reverse_on;
    logic       cfg_we = 1'b0;
    logic       cfg_index = 1'b0;
    logic [7:0] cfg_data = 8'd0;

    int fail_count;
    int pending;
    int bytes_sent = 0;
    int burst_left = 0;
    int quiet_cycles = 0;
    int scr_cols = aetr_pkg::COLS_RST;
    int scr_rows = aetr_pkg::ROWS_RST;
    int hold_req = 0;

    ansi_escape_text_renderer_unit dut (.*);

    aetr_draw_checker checker_i (
        .clk, .rst_n, .in_valid, .in_ready, .text_byte, .out_valid, .out_ready,
        .action, .row, .column, .glyph, .foreground, .background,
        .bold_on, .underline_on, .blink_on, .reverse_on,
        .cfg_we, .cfg_index, .cfg_data, .fail_count, .pending
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("ansi_escape_text_renderer_unit regression: fail");
            $finish;
        end
    end

    // receiver: stall pattern is redrawn at random intervals; one-shot long hold on request
    initial
    begin : receiver
        int mode;
        int mode_left;
        int tick;
        int holds_done;
        mode = 0;
        mode_left = 0;
        tick = 0;
        holds_done = 0;
        forever
        begin
            @(negedge clk);
            if (hold_req != holds_done)
            begin
                holds_done = hold_req;
                out_ready <= 1'b0;
                repeat (LONG_HOLD) @(negedge clk);
            end
            if (mode_left == 0)
            begin
                mode = $urandom_range(0, 3);
                mode_left = $urandom_range(20, 200);
            end
            mode_left--;
            tick++;
            case (mode)
                0:       out_ready <= 1'b1;
                1:       out_ready <= ($urandom_range(0, 3) != 0);
                2:       out_ready <= ($urandom_range(0, 3) == 0);
                default: out_ready <= ((tick % 5) < 2);
            endcase
        end
    end

    task automatic send_byte(input logic [7:0] b);
        int gap;
        @(negedge clk);
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 48);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
            if (gap != 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
        burst_left--;
        in_valid  <= 1'b1;
        text_byte <= b;
        do
            @(posedge clk);
        while (!in_ready);
        if (b != aetr_pkg::CH_CR)
            bytes_sent++;
    endtask

    task automatic send_str(input string s);
        for (int i = 0; i < s.len(); i++)
            send_byte(s[i]);
    endtask

    task automatic send_csi(input string body, input logic [7:0] fin);
        send_byte(aetr_pkg::CH_ESC);
        send_byte(aetr_pkg::CH_LBR);
        send_str(body);
        send_byte(fin);
    endtask

    task automatic drain_and_settle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input logic idx, input logic [7:0] val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    task automatic set_screen(input int c, input int r);
        drain_and_settle();
        write_reg(aetr_pkg::CFG_COLS, 8'(c));
        write_reg(aetr_pkg::CFG_ROWS, 8'(r));
        scr_cols = c;
        scr_rows = r;
    endtask

    function automatic int param_value(input logic [7:0] fin);
        int pick;
        pick = $urandom_range(0, 19);
        if (pick == 0)
            return -1;
        if (pick == 1)
            return $urandom_range(0, 99999);
        if (fin == aetr_pkg::CH_SGR)
            return $urandom_range(0, 49);
        return $urandom_range(0, ((scr_cols > scr_rows) ? scr_cols : scr_rows) + 2);
    endfunction

    task automatic send_random_csi();
        string body;
        logic [7:0] fin;
        int n_par;
        int v;
        body = "";
        case ($urandom_range(0, 11))
            0:       fin = aetr_pkg::CH_UP;
            1:       fin = aetr_pkg::CH_DOWN;
            2:       fin = aetr_pkg::CH_RIGHT;
            3:       fin = aetr_pkg::CH_LEFT;
            4, 5:    fin = aetr_pkg::CH_POS;
            6:       fin = ($urandom_range(0, 3) == 0) ? aetr_pkg::CH_ED : aetr_pkg::CH_EL;
            7:       fin = ($urandom_range(0, 1) == 0) ? aetr_pkg::CH_SAVE : aetr_pkg::CH_REST;
            default: fin = aetr_pkg::CH_SGR;
        endcase
        n_par = ($urandom_range(0, 15) == 0) ? $urandom_range(5, 20) : $urandom_range(0, 3);
        for (int i = 0; i < n_par; i++)
        begin
            if (i != 0)
                body = {body, ";"};
            v = param_value(fin);
            if (v >= 0)
                body = {body, $sformatf("%0d", v)};
        end
        send_csi(body, fin);
    endtask

    task automatic send_broken_escape();
        case ($urandom_range(0, 2))
            0:
            begin
                send_byte(aetr_pkg::CH_ESC);
                send_byte(8'($urandom_range(0, 255)));
            end
            1:
            begin
                send_byte(aetr_pkg::CH_ESC);
                send_byte(aetr_pkg::CH_LBR);
                send_str($sformatf("%0d", $urandom_range(0, 99)));
                send_byte(aetr_pkg::CH_ESC);
            end
            default:
            begin
                send_byte(aetr_pkg::CH_ESC);
                send_byte(aetr_pkg::CH_LBR);
                send_byte(8'($urandom_range(0, 255)));
            end
        endcase
    endtask

    task automatic random_stream(input int target);
        int stop_at;
        int kind;
        int len;
        stop_at = bytes_sent + target;
        while (bytes_sent < stop_at)
        begin
            kind = $urandom_range(0, 99);
            if (kind < 35)
            begin
                len = $urandom_range(1, 12);
                repeat (len)
                    send_byte(($urandom_range(0, 7) == 0) ? 8'($urandom_range(128, 255))
                                                          : 8'($urandom_range(32, 126)));
            end
            else if (kind < 40)
                send_byte(aetr_pkg::CH_LF);
            else if (kind < 78)
                send_random_csi();
            else if (kind < 88)
                send_byte(8'($urandom_range(0, 255)));
            else if (kind < 95)
                send_broken_escape();
            else
                send_byte(8'($urandom_range(0, 31)));
        end
    endtask

    initial
    begin : stimulus
        string many;
        int phase_cols [8];
        int phase_rows [8];
        phase_cols = '{0, 1, 255, 1, 255, 7, 80, 0};
        phase_rows = '{0, 1, 255, 255, 1, 5, 24, 0};

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        set_screen(10, 4);
        send_byte("A");
        send_byte(aetr_pkg::CH_SPACE);
        send_byte(8'h7E);
        send_byte(8'h80);
        send_byte(8'hFF);
        send_byte(8'h00);
        send_byte(aetr_pkg::CH_CR);
        send_byte(aetr_pkg::CH_DEL);
        send_byte(8'h1F);
        send_byte(aetr_pkg::CH_LF);
        send_byte(aetr_pkg::CH_ESC);
        send_byte(aetr_pkg::CH_ESC);
        send_csi("2", aetr_pkg::CH_DOWN);
        send_csi("5", aetr_pkg::CH_DOWN);
        send_csi("", aetr_pkg::CH_UP);
        send_csi("0", aetr_pkg::CH_RIGHT);
        send_csi("99999", aetr_pkg::CH_LEFT);
        send_byte(aetr_pkg::CH_ESC);
        send_byte("x");
        send_byte("y");
        send_csi("3;7", aetr_pkg::CH_POS);
        send_csi("1\r2", aetr_pkg::CH_RIGHT);
        send_csi(";5", aetr_pkg::CH_POS);
        send_csi("9;1", aetr_pkg::CH_POS);
        send_csi("0;0", aetr_pkg::CH_POS);
        send_csi("", aetr_pkg::CH_SAVE);
        send_csi("4;10", aetr_pkg::CH_POS);
        send_str("xyz");
        send_csi("", aetr_pkg::CH_REST);
        send_csi("", aetr_pkg::CH_EL);
        send_csi("1;4;5;7", aetr_pkg::CH_SGR);
        send_byte("a");
        send_csi("21", aetr_pkg::CH_SGR);
        send_csi("1", aetr_pkg::CH_SGR);
        send_csi("22", aetr_pkg::CH_SGR);
        send_csi("1", aetr_pkg::CH_SGR);
        send_csi("2", aetr_pkg::CH_SGR);
        send_byte("b");
        send_csi("24;25;27", aetr_pkg::CH_SGR);
        send_csi("31;42;99", aetr_pkg::CH_SGR);
        send_byte("c");
        send_csi("", aetr_pkg::CH_SGR);
        send_csi(";7", aetr_pkg::CH_SGR);
        send_byte("d");
        send_csi("36;45", aetr_pkg::CH_SGR);
        many = "";
        for (int i = 0; i < 16; i++)
            many = {many, "1;"};
        many = {many, "4;4;4"};
        send_csi(many, aetr_pkg::CH_SGR);
        send_byte("e");
        send_csi("3", "Z");
        send_csi("3", aetr_pkg::CH_ESC);
        send_byte("q");
        send_csi("", aetr_pkg::CH_ED);
        send_byte("z");
        send_csi("37;47;30;40", aetr_pkg::CH_SGR);
        send_byte("f");

        for (int p = 0; p < 8; p++)
        begin
            if (p == 7)
                set_screen($urandom_range(1, 255), $urandom_range(1, 255));
            else
                set_screen(phase_cols[p], phase_rows[p]);
            if (p == 2 || p == 5)
                hold_req++;
            random_stream(PHASE_BYTES);
        end

        drain_and_settle();
        if (fail_count == 0 && pending == 0)
            $display("ansi_escape_text_renderer_unit regression: pass");
        else
            $display("ansi_escape_text_renderer_unit regression: fail");
        $finish;
    end

endmodule
